// File: sv/tkn_pkg.sv
// Shared types, constants and character-class functions of the tokenizer.
package tkn_pkg;

   localparam int DEF_MAX_TOKEN_LEN = 128;
   localparam int HEAD_BYTES        = 6;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] KIND_IDENT   = 3'd0;
   localparam logic [2:0] KIND_KEYWORD = 3'd1;
   localparam logic [2:0] KIND_NUMBER  = 3'd2;
   localparam logic [2:0] KIND_OPER    = 3'd3;
   localparam logic [2:0] KIND_SYMBOL  = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;
   localparam logic [2:0] KIND_END     = 3'd6;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_OPER
   } mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] start_position;
      logic [7:0]  token_length;
      logic        truncated;
      logic        last_in_run;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [47:0] head_chars;
      logic [31:0] pending_start;
      logic [31:0] byte_position;
      logic        overflow_seen;
   } scan_state_type;

   typedef struct packed {
      logic [1:0] push_count;
      rsp_type    first;
      rsp_type    second;
   } queue_push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
             c == "<" || c == ">" || c == "!" || c == "&" || c == "|";
   endfunction

   function automatic logic is_follow(input logic [7:0] c);
      return c == "=" || c == "|" || c == "&";
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
             c == "]" || c == "," || c == ";";
   endfunction

   // The first byte of a token sits in the low bits, so each word is
   // written back to front here.
   function automatic logic kw_match(input logic [47:0] head, input logic [2:0] len);
      logic hit;
      case (len)
         3'd2: hit = head[15:0] == "fi";
         3'd3: hit = head[23:0] == "tni";
         3'd4: hit = head[31:0] == "esle" || head[31:0] == "rahc" ||
                     head[31:0] == "diov";
         3'd5: hit = head[39:0] == "elihw";
         3'd6: hit = head[47:0] == "nruter";
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// File: sv/tkn_scanner.sv
// Combinational scanner: next token state and result words for one byte.
module tkn_scanner import tkn_pkg::*; #(
   parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
   localparam int LenW = $clog2(MAX_TOKEN_LEN + 1)
) (
   input  logic           accept_in,
   input  req_type        req_in,
   input  scan_state_type state_in,
   input  logic [LenW-1:0] len_in,
   output scan_state_type state_out,
   output logic [LenW-1:0] len_out,
   output queue_push_type push_out
);

   logic [7:0]      c;
   logic            eot;
   logic            extend;
   logic            room;
   logic [LenW-1:0] len_app;
   logic [47:0]     head_app;
   logic            open_tok;
   logic            flush_valid;
   logic            begin_valid;
   logic [LenW-1:0] flush_len;
   logic            flush_trunc;
   logic            keyword;
   rsp_type         flush_tok;
   rsp_type         begin_tok;

   assign c   = req_in.ch;
   assign eot = req_in.end_of_text;

   assign extend = !eot &&
      ((state_in.mode == MODE_IDENT  && (is_letter(c) || is_digit(c))) ||
       (state_in.mode == MODE_NUMBER && is_digit(c)) ||
       (state_in.mode == MODE_OPER   && is_follow(c)));

   assign room     = len_in < LenW'(MAX_TOKEN_LEN);
   assign len_app  = room ? len_in + LenW'(1) : len_in;
   assign open_tok = !eot && !extend && (is_letter(c) || is_digit(c) || is_oper(c));

   always_comb begin
      head_app = state_in.head_chars;
      for (int i = 0; i < HEAD_BYTES; i++) begin
         if (room && len_in == LenW'(i)) begin
            head_app[8*i +: 8] = c;
         end
      end
   end

   assign flush_valid = state_in.mode != MODE_START &&
                        (eot || !extend || state_in.mode == MODE_OPER);
   assign begin_valid = eot || (!extend && !open_tok && !is_space(c));

   assign flush_len   = (extend && state_in.mode == MODE_OPER) ? len_app : len_in;
   assign flush_trunc = state_in.overflow_seen;
   assign keyword     = !state_in.overflow_seen && len_in <= LenW'(HEAD_BYTES) &&
                        kw_match(state_in.head_chars, 3'(len_in));

   // Next state.
   always_comb begin
      state_out = state_in;
      len_out   = len_in;
      if (eot) begin
         state_out.mode = MODE_START;
      end else begin
         state_out.byte_position = state_in.byte_position + 32'd1;
         if (extend) begin
            len_out                  = len_app;
            state_out.head_chars     = head_app;
            state_out.overflow_seen  = state_in.overflow_seen | !room;
            if (state_in.mode == MODE_OPER) begin
               state_out.mode = MODE_START;
            end
         end else if (open_tok) begin
            state_out.mode          = is_letter(c) ? MODE_IDENT :
                                      is_digit(c)  ? MODE_NUMBER : MODE_OPER;
            state_out.pending_start = state_in.byte_position;
            state_out.head_chars    = {40'd0, c};
            state_out.overflow_seen = 1'b0;
            len_out                 = LenW'(1);
         end else begin
            state_out.mode = MODE_START;
         end
      end
   end

   // Result words.
   always_comb begin
      case (state_in.mode)
         MODE_IDENT:  flush_tok.kind = keyword ? KIND_KEYWORD : KIND_IDENT;
         MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
         default:     flush_tok.kind = KIND_OPER;
      endcase
      flush_tok.start_position = state_in.pending_start;
      flush_tok.token_length   = 8'(flush_len);
      flush_tok.truncated      = flush_trunc;
      flush_tok.last_in_run    = !begin_valid;

      begin_tok.kind           = eot ? KIND_END : (is_symbol(c) ? KIND_SYMBOL : KIND_ERROR);
      begin_tok.start_position = state_in.byte_position;
      begin_tok.token_length   = eot ? 8'd0 : 8'd1;
      begin_tok.truncated      = 1'b0;
      begin_tok.last_in_run    = 1'b1;

      push_out.first      = flush_valid ? flush_tok : begin_tok;
      push_out.second     = begin_tok;
      push_out.push_count = accept_in ? 2'({1'b0, flush_valid} + {1'b0, begin_valid})
                                      : 2'd0;
   end

endmodule

// File: sv/tkn_rsp_queue.sv
// Small result queue taking up to two words per cycle and giving one unless rsp_stall is high.
module tkn_rsp_queue import tkn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_push_type         push_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   output logic [QUEUE_LVL_W-1:0] level
);

   rsp_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_LVL_W-1:0] level_ff, level_in;
   logic                   pop;

   assign rsp_valid   = level_ff != '0;
   assign rsp_payload = slot_ff[rd_ff];
   assign level       = level_ff;
   assign pop         = rsp_valid && !rsp_stall;

   assign wr_in    = wr_ff + QUEUE_PTR_W'(push_in.push_count);
   assign rd_in    = rd_ff + QUEUE_PTR_W'(pop);
   assign level_in = level_ff + QUEUE_LVL_W'(push_in.push_count) - QUEUE_LVL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push_count != 2'd0) begin
         slot_ff[wr_ff] <= push_in.first;
      end
      if (push_in.push_count == 2'd2) begin
         slot_ff[wr_ff + QUEUE_PTR_W'(1)] <= push_in.second;
      end
   end

endmodule

// File: sv/c_subset_tokenizer_unit.sv
// Top level of the C-subset tokenizer: token state registers and result queue.
//
// The tokenizer takes one source byte per request word and returns token
// words (kind, start position, length, truncation flag and a last-in-run
// mark) on the response channel. A new byte is taken in every cycle while req_stall
// is low: the scanner works out the next token state and up to two result words in one
// pass of shallow logic from the state registers, and the words enter a
// four-entry result queue. When the queue is empty, the first result word of
// a byte is offered on the response channel in the cycle after the byte is
// accepted; otherwise it waits behind the words already queued. The response
// side drains one word per cycle unless rsp_stall is high, so a byte that
// yields two words (a symbol or error byte ending a pending token, or end of
// text with a token pending) takes up an extra output slot; req_stall rises
// whenever the queue has fewer than two free entries, so sustained throughput
// is one byte per cycle as long as the bytes yield on average no more than one word
// each and the response side does not stall. End of text flushes any pending token, adds
// an end word and leaves the byte counter where it was, so further text may
// follow. Tokens longer than MAX_TOKEN_LEN report that length and are flagged
// as truncated; a truncated identifier is never taken for a keyword.
module c_subset_tokenizer_unit import tkn_pkg::*; #(
   parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);

   scan_state_type         state_ff, state_in;
   logic [LenW-1:0]        len_ff, len_in;
   logic                   accept;
   queue_push_type         push;
   logic [QUEUE_LVL_W-1:0] level;

   // Two free entries are needed, since one byte may produce two words.
   assign req_stall = level > QUEUE_LVL_W'(QUEUE_DEPTH - 2);
   assign accept    = req_valid && !req_stall;

   tkn_scanner #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_scanner (
      .accept_in(accept),
      .req_in   (req_payload),
      .state_in (state_ff),
      .len_in   (len_ff),
      .state_out(state_in),
      .len_out  (len_in),
      .push_out (push)
   );

   tkn_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .level      (level)
   );

   // The token state moves only when a byte or end-of-text word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_START, head_chars: '0, pending_start: '0,
                       byte_position: '0, overflow_seen: 1'b0};
         len_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
   end

   // The queue must never be asked to hold more words than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // An accepted text byte moves the byte counter on by exactly one.
   a_position_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_payload.end_of_text |=>
         state_ff.byte_position == $past(state_ff.byte_position) + 32'd1)
      else $error("byte position did not advance");

   // End of text leaves the counter alone and the scanner with no token pending.
   a_end_flush: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_text |=>
         state_ff.mode == MODE_START && $stable(state_ff.byte_position))
      else $error("end of text did not flush the scanner");

   // An accepted end-of-text word always produces at least one result.
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.end_of_text |-> push.push_count != 2'd0)
      else $error("end of text produced no end word");

endmodule
